// ===== sv/slc_pkg.sv =====
// ----------------------------------------------------------------------------
// slc_pkg: shared types and codes for the slot cache
// Request action codes, sequencer states and the status groups passed
// between the storage, scan and control logic.
// ----------------------------------------------------------------------------
package slc_pkg;

  // request action codes
  typedef enum logic [1:0] {
    ACT_RESIDENT = 2'd0,
    ACT_PIN      = 2'd1,
    ACT_UNPIN    = 2'd2
  } action_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_DRAIN  = 2'd2,
    ST_UPDATE = 2'd3
  } state_t;

  // field widths
  localparam int unsigned ID_W    = 16;
  localparam int unsigned STAMP_W = 64;
  localparam int unsigned SLOT_W  = 3;

  // write controls toward the entry store
  typedef struct packed {
    logic id_we;
    logic stamp_we;
    logic set_valid;
    logic pin_we;
    logic pin_val;
  } store_wr_t;

  // outcome of one scan over all entries
  typedef struct packed {
    logic hit;
    logic free_found;
    logic lru_found;
  } scan_flags_t;

endpackage

// ===== sv/slc_store.sv =====
// ----------------------------------------------------------------------------
// slc_store: entry storage of the slot cache
// Id and stamp memories with one registered read port and one write port,
// plus valid and pin flags in flip-flops.
// ----------------------------------------------------------------------------
module slc_store #(
  parameter int unsigned SLOTS = 8,
  parameter int unsigned SW    = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [SW-1:0]               rd_addr,
  output logic [slc_pkg::ID_W-1:0]    rd_id,
  output logic [slc_pkg::STAMP_W-1:0] rd_stamp,
  input  slc_pkg::store_wr_t          wr_ctl,
  input  logic [SW-1:0]               wr_addr,
  input  logic [slc_pkg::ID_W-1:0]    wr_id,
  input  logic [slc_pkg::STAMP_W-1:0] wr_stamp,
  output logic [SLOTS-1:0]            valid_bits,
  output logic [SLOTS-1:0]            pinned_bits
);

  logic [slc_pkg::ID_W-1:0]    id_mem    [SLOTS];
  logic [slc_pkg::STAMP_W-1:0] stamp_mem [SLOTS];

  // id memory
  always_ff @(posedge clk) begin
    if (wr_ctl.id_we) begin
      id_mem[wr_addr] <= wr_id;
    end
    rd_id <= id_mem[rd_addr];
  end

  // stamp memory
  always_ff @(posedge clk) begin
    if (wr_ctl.stamp_we) begin
      stamp_mem[wr_addr] <= wr_stamp;
    end
    rd_stamp <= stamp_mem[rd_addr];
  end

  // valid and pin flags
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits  <= '0;
      pinned_bits <= '0;
    end else begin
      if (wr_ctl.set_valid) begin
        valid_bits[wr_addr] <= 1'b1;
      end
      if (wr_ctl.pin_we) begin
        pinned_bits[wr_addr] <= wr_ctl.pin_val;
      end
    end
  end

endmodule

// ===== sv/slc_scan.sv =====
// ----------------------------------------------------------------------------
// slc_scan: shared compare unit of the slot cache
// Looks at one entry per cycle and keeps the first id match, the first
// free entry and the oldest unpinned entry seen so far.
// ----------------------------------------------------------------------------
module slc_scan #(
  parameter int unsigned SW = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        cmp_en,
  input  logic [SW-1:0]               cmp_idx,
  input  logic                        cmp_valid,
  input  logic                        cmp_pinned,
  input  logic [slc_pkg::ID_W-1:0]    cmp_id,
  input  logic [slc_pkg::STAMP_W-1:0] cmp_stamp,
  input  logic [slc_pkg::ID_W-1:0]    req_id,
  output slc_pkg::scan_flags_t        flags,
  output logic [SW-1:0]               hit_idx,
  output logic [SW-1:0]               free_idx,
  output logic [SW-1:0]               lru_idx,
  output logic [slc_pkg::ID_W-1:0]    lru_id
);

  logic [slc_pkg::STAMP_W-1:0] lru_stamp;
  logic                        id_match;
  logic                        older;

  // one id compare and one stamp compare per cycle
  assign id_match = cmp_valid && (cmp_id == req_id);
  assign older    = !flags.lru_found || (cmp_stamp < lru_stamp);

  // flags
  always_ff @(posedge clk) begin
    if (rst || start) begin
      flags <= '0;
    end else if (cmp_en) begin
      if (id_match) begin
        flags.hit <= 1'b1;
      end
      if (!cmp_valid) begin
        flags.free_found <= 1'b1;
      end
      if (cmp_valid && !cmp_pinned) begin
        flags.lru_found <= 1'b1;
      end
    end
  end

  // captured indexes and oldest entry, lowest index wins on ties
  always_ff @(posedge clk) begin
    if (cmp_en) begin
      if (id_match && !flags.hit) begin
        hit_idx <= cmp_idx;
      end
      if (!cmp_valid && !flags.free_found) begin
        free_idx <= cmp_idx;
      end
      if (cmp_valid && !cmp_pinned && older) begin
        lru_idx   <= cmp_idx;
        lru_id    <= cmp_id;
        lru_stamp <= cmp_stamp;
      end
    end
  end

endmodule

// ===== sv/slot_cache_lru_with_pinning.sv =====
// ----------------------------------------------------------------------------
// slot_cache_lru_with_pinning: fully associative LRU slot cache with pinning
// Each request makes an id resident, pins it or unpins it; one response
// per request reports hit, load, eviction, slot and no-room status.
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------------------
//   req     | req_valid / req_stall | action, item_id
//   rsp     | rsp_valid / rsp_stall | was_resident, load_issued,
//           |                       | evict_issued, evicted_id,
//           |                       | slot_number, no_room
//
// A request is accepted in the idle state, then the scan state sends one
// entry per cycle through the shared id/stamp compare unit, which is fed
// from the entry memories read one address a cycle; the drain state covers
// the last registered read, and the update state commits the result.
// req_stall is high while a request is in flight. The response sits in an
// output register, so a new request is taken while it waits; the update
// cycle holds while a previous response is still stalled.
// Reset clears the valid and pin flags and the use counter at once.
// ----------------------------------------------------------------------------
module slot_cache_lru_with_pinning #(
  parameter int unsigned SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  action,
  input  logic [15:0] item_id,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic        was_resident,
  output logic        load_issued,
  output logic        evict_issued,
  output logic [15:0] evicted_id,
  output logic [2:0]  slot_number,
  output logic        no_room
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  slc_pkg::state_t             state, state_next;
  logic [1:0]                  req_action;
  logic [slc_pkg::ID_W-1:0]    req_id;
  logic [SW-1:0]               rd_addr;
  logic                        cmp_en;
  logic [SW-1:0]               cmp_idx;
  logic [slc_pkg::STAMP_W-1:0] use_counter;
  logic [slc_pkg::STAMP_W-1:0] use_counter_next;

  logic                        accept;
  logic                        scan_last;
  logic                        out_free;
  logic                        commit;

  logic [slc_pkg::ID_W-1:0]    rd_id;
  logic [slc_pkg::STAMP_W-1:0] rd_stamp;
  logic [SLOTS-1:0]            valid_bits;
  logic [SLOTS-1:0]            pinned_bits;

  slc_pkg::scan_flags_t        flags;
  logic [SW-1:0]               hit_idx;
  logic [SW-1:0]               free_idx;
  logic [SW-1:0]               lru_idx;
  logic [slc_pkg::ID_W-1:0]    lru_id;

  slc_pkg::store_wr_t          wr_ctl;
  logic [SW-1:0]               wr_addr;
  logic                        bump;
  logic                        res_was;
  logic                        res_load;
  logic                        res_evict;
  logic [slc_pkg::ID_W-1:0]    res_evid;
  logic [SW-1:0]               res_slot;
  logic                        res_noroom;

  // entry storage
  slc_store #(
    .SLOTS (SLOTS),
    .SW    (SW)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .rd_addr     (rd_addr),
    .rd_id       (rd_id),
    .rd_stamp    (rd_stamp),
    .wr_ctl      (wr_ctl),
    .wr_addr     (wr_addr),
    .wr_id       (req_id),
    .wr_stamp    (use_counter_next),
    .valid_bits  (valid_bits),
    .pinned_bits (pinned_bits)
  );

  // shared compare unit
  slc_scan #(
    .SW (SW)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .start      (accept),
    .cmp_en     (cmp_en),
    .cmp_idx    (cmp_idx),
    .cmp_valid  (valid_bits[cmp_idx]),
    .cmp_pinned (pinned_bits[cmp_idx]),
    .cmp_id     (rd_id),
    .cmp_stamp  (rd_stamp),
    .req_id     (req_id),
    .flags      (flags),
    .hit_idx    (hit_idx),
    .free_idx   (free_idx),
    .lru_idx    (lru_idx),
    .lru_id     (lru_id)
  );

  assign scan_last        = (rd_addr == SW'(SLOTS - 1));
  assign out_free         = !rsp_valid || !rsp_stall;
  assign use_counter_next = use_counter + 64'd1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      slc_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = slc_pkg::ST_SCAN;
        end
      end
      slc_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_next = slc_pkg::ST_DRAIN;
        end
      end
      slc_pkg::ST_DRAIN: begin
        state_next = slc_pkg::ST_UPDATE;
      end
      slc_pkg::ST_UPDATE: begin
        if (out_free) begin
          state_next = slc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = slc_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    req_stall = 1'b1;
    commit    = 1'b0;
    case (state)
      slc_pkg::ST_IDLE: begin
        req_stall = 1'b0;
      end
      slc_pkg::ST_UPDATE: begin
        commit = out_free;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  assign accept = req_valid && !req_stall;

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= slc_pkg::ST_IDLE;
      cmp_en <= 1'b0;
    end else begin
      state  <= state_next;
      cmp_en <= (state == slc_pkg::ST_SCAN);
    end
  end

  // request capture and scan address
  always_ff @(posedge clk) begin
    if (accept) begin
      req_action <= action;
      req_id     <= item_id;
      rd_addr    <= '0;
    end else if (state == slc_pkg::ST_SCAN && !scan_last) begin
      rd_addr <= rd_addr + SW'(1);
    end
    cmp_idx <= rd_addr;
  end

  // decision from the scan outcome
  always_comb begin
    wr_ctl     = '0;
    wr_addr    = hit_idx;
    bump       = 1'b0;
    res_was    = flags.hit;
    res_load   = 1'b0;
    res_evict  = 1'b0;
    res_evid   = '0;
    res_slot   = flags.hit ? hit_idx : '0;
    res_noroom = 1'b0;
    case (req_action)
      slc_pkg::ACT_RESIDENT: begin
        if (flags.hit) begin
          wr_ctl.stamp_we = 1'b1;
          bump            = 1'b1;
        end else if (flags.free_found || flags.lru_found) begin
          wr_addr          = flags.free_found ? free_idx : lru_idx;
          wr_ctl.id_we     = 1'b1;
          wr_ctl.stamp_we  = 1'b1;
          wr_ctl.set_valid = 1'b1;
          wr_ctl.pin_we    = 1'b1;
          wr_ctl.pin_val   = 1'b0;
          bump             = 1'b1;
          res_load         = 1'b1;
          res_slot         = wr_addr;
          if (!flags.free_found) begin
            res_evict = 1'b1;
            res_evid  = lru_id;
          end
        end else begin
          res_noroom = 1'b1;
        end
      end
      slc_pkg::ACT_PIN: begin
        wr_ctl.pin_we  = flags.hit;
        wr_ctl.pin_val = 1'b1;
      end
      slc_pkg::ACT_UNPIN: begin
        wr_ctl.pin_we  = flags.hit;
        wr_ctl.pin_val = 1'b0;
      end
      default: begin
        wr_ctl = '0;
      end
    endcase
    // writes happen only in the committing cycle
    if (!commit) begin
      wr_ctl = '0;
      bump   = 1'b0;
    end
  end

  // use counter
  always_ff @(posedge clk) begin
    if (rst) begin
      use_counter <= '0;
    end else if (bump) begin
      use_counter <= use_counter_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      was_resident <= res_was;
      load_issued  <= res_load;
      evict_issued <= res_evict;
      evicted_id   <= res_evid;
      slot_number  <= slc_pkg::SLOT_W'(res_slot);
      no_room      <= res_noroom;
    end
  end

endmodule

// ===== tb/tb_slot_cache_lru_with_pinning.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_slot_cache_lru_with_pinning: self-checking bench for the slot cache
// Drives make-resident, pin and unpin requests with random bursts and gaps,
// stalls the response side on its own pattern, and compares every response
// field against an LRU residency tracker kept in step with the requests.
// ----------------------------------------------------------------------------
module tb_slot_cache_lru_with_pinning;

  localparam int NUM_SLOTS    = 8;
  localparam int RANDOM_ITEMS = 700;
  localparam int POOL_SIZE    = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 2 * NUM_SLOTS + 8;

  // action code left undefined by the block; must be ignored
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY} stall_mode_t;

  typedef struct packed {
    logic        was_resident;
    logic        load_issued;
    logic        evict_issued;
    logic [15:0] evicted_id;
    logic [2:0]  slot_number;
    logic        no_room;
  } rsp_t;

  // tracks residency, pins and LRU stamps; queues the expected responses
  class residency_tracker;
    logic [15:0] held_id     [NUM_SLOTS];
    bit          held_valid  [NUM_SLOTS];
    bit          held_pinned [NUM_SLOTS];
    logic [63:0] held_stamp  [NUM_SLOTS];
    logic [63:0] use_count;
    rsp_t        expected_rsp[$];
    int          mismatches;

    function new();
      foreach (held_valid[i]) begin
        held_id[i]     = '0;
        held_valid[i]  = 1'b0;
        held_pinned[i] = 1'b0;
        held_stamp[i]  = '0;
      end
      use_count  = '0;
      mismatches = 0;
    endfunction

    function void note_request(logic [1:0] act, logic [15:0] id);
      rsp_t        r;
      int          hit;
      int          target;
      bit          found;
      logic [63:0] best;
      r      = '0;
      hit    = -1;
      target = -1;
      found  = 1'b0;
      best   = '0;
      // associative lookup, lowest matching slot
      for (int i = 0; i < NUM_SLOTS; i++)
        if (hit < 0 && held_valid[i] && held_id[i] == id) hit = i;
      if (hit >= 0) begin
        r.was_resident = 1'b1;
        r.slot_number  = hit[2:0];
      end
      if (act == slc_pkg::ACT_RESIDENT) begin
        if (hit >= 0) begin
          use_count       = use_count + 1;
          held_stamp[hit] = use_count;
        end else begin
          // lowest free slot first
          for (int i = 0; i < NUM_SLOTS; i++)
            if (target < 0 && !held_valid[i]) target = i;
          // otherwise oldest unpinned, lowest index on ties
          if (target < 0) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
              if (!held_pinned[i] && (!found || held_stamp[i] < best)) begin
                found  = 1'b1;
                best   = held_stamp[i];
                target = i;
              end
            end
            if (target >= 0) begin
              r.evict_issued = 1'b1;
              r.evicted_id   = held_id[target];
            end
          end
          if (target < 0) begin
            r.no_room = 1'b1;
          end else begin
            held_id[target]     = id;
            held_valid[target]  = 1'b1;
            held_pinned[target] = 1'b0;
            use_count           = use_count + 1;
            held_stamp[target]  = use_count;
            r.load_issued       = 1'b1;
            r.slot_number       = target[2:0];
          end
        end
      end else if (act == slc_pkg::ACT_PIN || act == slc_pkg::ACT_UNPIN) begin
        if (hit >= 0) held_pinned[hit] = (act == slc_pkg::ACT_PIN);
      end
      expected_rsp.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_rsp.size() == 0) begin
        $display("%0t: response with none outstanding, expected none actual %p",
                 $time, got);
        mismatches++;
      end else begin
        want = expected_rsp.pop_front();
        compare_field("was_resident", 16'(want.was_resident), 16'(got.was_resident));
        compare_field("load_issued",  16'(want.load_issued),  16'(got.load_issued));
        compare_field("evict_issued", 16'(want.evict_issued), 16'(got.evict_issued));
        compare_field("evicted_id",   want.evicted_id,        got.evicted_id);
        compare_field("slot_number",  16'(want.slot_number),  16'(got.slot_number));
        compare_field("no_room",      16'(want.no_room),      16'(got.no_room));
      end
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  logic [1:0]  action;
  logic [15:0] item_id;
  logic        rsp_valid;
  logic        rsp_stall;
  logic        was_resident;
  logic        load_issued;
  logic        evict_issued;
  logic [15:0] evicted_id;
  logic [2:0]  slot_number;
  logic        no_room;

  residency_tracker tracker;
  bit               hold_off_request;

  slot_cache_lru_with_pinning #(
    .SLOTS(NUM_SLOTS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .action      (action),
    .item_id     (item_id),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .was_resident(was_resident),
    .load_issued (load_issued),
    .evict_issued(evict_issued),
    .evicted_id  (evicted_id),
    .slot_number (slot_number),
    .no_room     (no_room)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // offer one request and hold it until the block takes it
  task automatic offer_request(input logic [1:0] act, input logic [15:0] id);
    req_valid <= 1'b1;
    action    <= act;
    item_id   <= id;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    tracker.note_request(act, id);
  endtask

  // response side back-pressure, with one long hold-off on request
  initial begin
    stall_mode_t mode;
    int          seg_len;
    bit          hold_done;
    hold_done  = 1'b0;
    rsp_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_request && !hold_done) begin
        hold_done = 1'b1;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode    = stall_mode_t'($urandom_range(0, 2));
        seg_len = $urandom_range(10, 80);
        repeat (seg_len) begin
          case (mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_HALF:  rsp_stall <= ($urandom_range(0, 1) == 1);
            default:     rsp_stall <= ($urandom_range(0, 7) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall)
      tracker.check_response({was_resident, load_issued, evict_issued,
                              evicted_id, slot_number, no_room});
  end

  // run limit
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // stimulus
  initial begin
    logic [15:0] id_pool [POOL_SIZE];
    logic [1:0]  act;
    logic [15:0] id;
    int          sent;
    int          burst_len;
    int          roll;
    bit          pin_heavy;
    tracker   = new();
    rst       <= 1'b1;
    req_valid <= 1'b0;
    action    <= slc_pkg::ACT_RESIDENT;
    item_id   <= 16'h0000;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: absent pin/unpin, fills, hit, unused code
    offer_request(slc_pkg::ACT_PIN, 16'hFFFF);
    offer_request(slc_pkg::ACT_UNPIN, 16'h0000);
    offer_request(slc_pkg::ACT_RESIDENT, 16'h0000);
    offer_request(slc_pkg::ACT_RESIDENT, 16'hFFFF);
    offer_request(slc_pkg::ACT_RESIDENT, 16'h0000);
    offer_request(ACT_UNUSED, 16'hFFFF);
    offer_request(ACT_UNUSED, 16'h1234);
    for (int k = 1; k <= 6; k++) offer_request(slc_pkg::ACT_RESIDENT, 16'h1000 + 16'(k));
    // full: evicts the oldest entry
    offer_request(slc_pkg::ACT_RESIDENT, 16'h2000);
    // pin everything, then a miss finds no room
    offer_request(slc_pkg::ACT_PIN, 16'h0000);
    offer_request(slc_pkg::ACT_PIN, 16'h2000);
    for (int k = 1; k <= 6; k++) offer_request(slc_pkg::ACT_PIN, 16'h1000 + 16'(k));
    offer_request(slc_pkg::ACT_RESIDENT, 16'h3000);
    // one unpinned entry becomes the only victim
    offer_request(slc_pkg::ACT_UNPIN, 16'h1003);
    offer_request(slc_pkg::ACT_RESIDENT, 16'h3000);

    // random: mostly a small id pool so hits, pins and evictions recur
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'h2000;
    for (int k = 1; k <= 6; k++) id_pool[k + 1] = 16'h1000 + 16'(k);
    id_pool[8] = 16'h3000;
    id_pool[9] = 16'hFFFF;
    id_pool[10] = 16'($urandom);
    id_pool[11] = 16'($urandom);
    pin_heavy        = 1'b0;
    hold_off_request = 1'b1;
    sent             = 0;
    while (sent < RANDOM_ITEMS) begin
      burst_len = $urandom_range(1, 20);
      for (int k = 0; k < burst_len && sent < RANDOM_ITEMS; k++) begin
        // occasionally swap in fresh ids and change the pin mix
        if (sent % 100 == 99) begin
          repeat ($urandom_range(1, 4)) id_pool[$urandom_range(0, POOL_SIZE - 1)] =
            16'($urandom);
          pin_heavy = ($urandom_range(0, 2) == 0);
        end
        roll = $urandom_range(0, 99);
        if (pin_heavy)
          act = (roll < 45) ? slc_pkg::ACT_RESIDENT :
                (roll < 88) ? slc_pkg::ACT_PIN :
                (roll < 96) ? slc_pkg::ACT_UNPIN : ACT_UNUSED;
        else
          act = (roll < 55) ? slc_pkg::ACT_RESIDENT :
                (roll < 78) ? slc_pkg::ACT_PIN :
                (roll < 96) ? slc_pkg::ACT_UNPIN : ACT_UNUSED;
        if ($urandom_range(0, 7) == 0)
          id = 16'($urandom);
        else
          id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        offer_request(act, id);
        sent++;
      end
      // gap between bursts, sometimes none
      if ($urandom_range(0, 3) != 0) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    req_valid <= 1'b0;

    // drain outstanding responses, then watch for strays
    while (tracker.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== slot_cache_lru_with_pinning.f =====
sv/slc_pkg.sv
sv/slc_store.sv
sv/slc_scan.sv
sv/slot_cache_lru_with_pinning.sv
tb/tb_slot_cache_lru_with_pinning.sv
